/* rtl/sha512_pkg.sv */
// sha512_pkg: shared types, constants and functions of the sha-512 family hash engine
// used by sha512_front, sha512_queue, sha512_core, sha512_family_hash_top and the bench
`timescale 1ns / 1ps
`default_nettype none

package sha512_pkg;

    localparam int ROUNDS_DEF  = 80;
    localparam int QUEUE_DEPTH = 4;

    // variant codes
    localparam logic [1:0] VAR_SHA512     = 2'd0;
    localparam logic [1:0] VAR_SHA384     = 2'd1;
    localparam logic [1:0] VAR_SHA512_224 = 2'd2;
    localparam logic [1:0] VAR_SHA512_256 = 2'd3;

    // queue entry: one schedule word plus a message-end marker
    typedef struct packed {
        logic [63:0] word;
        logic        final_word;
    } sched_beat_t;

    typedef enum logic [2:0] {
        CORE_LOAD,
        CORE_ROUND,
        CORE_ADD,
        CORE_EMIT
    } core_state_t;

    typedef enum logic [1:0] {
        FRONT_TAKE,
        FRONT_PAD,
        FRONT_LEN_HI,
        FRONT_LEN_LO
    } front_state_t;

    function automatic logic [63:0] round_const(input logic [6:0] t);
        logic [63:0] k;
        case (t)
            7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

    function automatic logic [63:0] init_value(input logic [1:0] v, input logic [2:0] i);
        logic [63:0] h;
        case ({v, i})
            5'd0:  h = 64'h6a09e667f3bcc908;  5'd1:  h = 64'hbb67ae8584caa73b;
            5'd2:  h = 64'h3c6ef372fe94f82b;  5'd3:  h = 64'ha54ff53a5f1d36f1;
            5'd4:  h = 64'h510e527fade682d1;  5'd5:  h = 64'h9b05688c2b3e6c1f;
            5'd6:  h = 64'h1f83d9abfb41bd6b;  5'd7:  h = 64'h5be0cd19137e2179;
            5'd8:  h = 64'hcbbb9d5dc1059ed8;  5'd9:  h = 64'h629a292a367cd507;
            5'd10: h = 64'h9159015a3070dd17;  5'd11: h = 64'h152fecd8f70e5939;
            5'd12: h = 64'h67332667ffc00b31;  5'd13: h = 64'h8eb44a8768581511;
            5'd14: h = 64'hdb0c2e0d64f98fa7;  5'd15: h = 64'h47b5481dbefa4fa4;
            5'd16: h = 64'h8c3d37c819544da2;  5'd17: h = 64'h73e1996689dcd4d6;
            5'd18: h = 64'h1dfab7ae32ff9c82;  5'd19: h = 64'h679dd514582f9fcf;
            5'd20: h = 64'h0f6d2b697bd44da8;  5'd21: h = 64'h77e36f7304c48942;
            5'd22: h = 64'h3f9d85a86a1d36c8;  5'd23: h = 64'h1112e6ad91d692a1;
            5'd24: h = 64'h22312194fc2bf72c;  5'd25: h = 64'h9f555fa3c84c64c2;
            5'd26: h = 64'h2393b86b6f53b151;  5'd27: h = 64'h963877195940eabd;
            5'd28: h = 64'h96283ee2a88effe3;  5'd29: h = 64'hbe5e1e2553863992;
            5'd30: h = 64'h2b0199fc2c85b8aa;  5'd31: h = 64'h0eb72ddc81c52ca2;
            default: h = 64'h0;
        endcase
        return h;
    endfunction

    // index of the last digest word per variant
    function automatic logic [2:0] last_index(input logic [1:0] v);
        logic [2:0] n;
        case (v)
            VAR_SHA512: n = 3'd7;
            VAR_SHA384: n = 3'd5;
            default:    n = 3'd3;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

/* rtl/sha512_front.sv */
// sha512_front: takes message beats, masks and pads the last word, appends the length
// depends on sha512_pkg; feeds schedule words into the queue towards sha512_core
`timescale 1ns / 1ps
`default_nettype none

module sha512_front (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    restart,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [63:0]             s_message_word,
    input  wire logic [3:0]              s_valid_bytes,
    input  wire logic                    s_last_word,
    input  wire logic                    q_ready,
    output logic                         q_valid,
    output sha512_pkg::sched_beat_t      q_beat
);

    sha512_pkg::front_state_t state_reg, state_next;
    logic [3:0]  pos_reg, pos_next;
    logic [60:0] count_reg, count_next;
    logic        pad_first_reg, pad_first_next;
    logic [3:0]  nb;
    logic [63:0] mask, masked, padded;
    logic [60:0] count_sum;
    logic        push;

    // clamp byte count and build the byte mask
    always_comb begin
        nb = (s_valid_bytes > 4'd8) ? 4'd8 : s_valid_bytes;
        mask = (nb == 4'd0) ? 64'h0 : ~(64'hffff_ffff_ffff_ffff >> {nb[3:0], 3'b000});
        masked = s_message_word & mask;
        padded = masked | ((nb == 4'd8) ? 64'h0 : (64'h8000_0000_0000_0000 >> {nb, 3'b000}));
        count_sum = count_reg + (s_last_word ? {57'd0, nb} : 61'd8);
    end

    // next state and queue writes
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        s_ready    = 1'b0;
        q_valid    = 1'b0;
        q_beat     = '0;
        push       = 1'b0;
        case (state_reg)
            sha512_pkg::FRONT_TAKE: begin
                s_ready = q_ready && !restart;
                q_valid = s_valid && !restart;
                if (s_last_word && nb == 4'd8) begin
                    q_beat.word = masked;
                end else if (s_last_word) begin
                    q_beat.word = padded;
                end else begin
                    q_beat.word = s_message_word;
                end
                q_beat.final_word = 1'b0;
                if (s_valid && q_ready && !restart) begin
                    push       = 1'b1;
                    count_next = count_sum;
                    if (s_last_word) begin
                        if (nb == 4'd8) begin
                            state_next = sha512_pkg::FRONT_PAD;
                        end else if (pos_reg == 4'd13) begin
                            state_next = sha512_pkg::FRONT_LEN_HI;
                        end else begin
                            state_next = sha512_pkg::FRONT_PAD;
                        end
                    end
                end
            end
            sha512_pkg::FRONT_PAD: begin
                q_valid     = 1'b1;
                q_beat.word = (count_reg[2:0] == 3'd0 && pad_first_reg) ?
                              64'h8000_0000_0000_0000 : 64'h0;
                if (q_ready) begin
                    push = 1'b1;
                    if (pos_reg == 4'd13) begin
                        state_next = sha512_pkg::FRONT_LEN_HI;
                    end
                end
            end
            sha512_pkg::FRONT_LEN_HI: begin
                q_valid = 1'b1;
                if (q_ready) begin
                    push       = 1'b1;
                    state_next = sha512_pkg::FRONT_LEN_LO;
                end
            end
            sha512_pkg::FRONT_LEN_LO: begin
                q_valid           = 1'b1;
                q_beat.word       = {count_reg, 3'b000};
                q_beat.final_word = 1'b1;
                if (q_ready) begin
                    push       = 1'b1;
                    count_next = '0;
                    state_next = sha512_pkg::FRONT_TAKE;
                end
            end
            default: state_next = sha512_pkg::FRONT_TAKE;
        endcase
        if (push) begin
            pos_next = pos_reg + 4'd1;
        end
    end

    // the full-word case still owes the 0x80 word
    always_comb begin
        pad_first_next = pad_first_reg;
        if (state_reg == sha512_pkg::FRONT_TAKE && push) begin
            pad_first_next = s_last_word && nb == 4'd8;
        end else if (state_reg == sha512_pkg::FRONT_PAD && push) begin
            pad_first_next = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            state_reg     <= sha512_pkg::FRONT_TAKE;
            pos_reg       <= '0;
            count_reg     <= '0;
            pad_first_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            pad_first_reg <= pad_first_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/sha512_queue.sv */
// sha512_queue: short fifo of schedule words between front and compression core
// depends on sha512_pkg for the beat type
`timescale 1ns / 1ps
`default_nettype none

module sha512_queue #(
    parameter int DEPTH = sha512_pkg::QUEUE_DEPTH
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    restart,
    input  wire logic                    wr_valid,
    output logic                         wr_ready,
    input  wire sha512_pkg::sched_beat_t wr_beat,
    output logic                         rd_valid,
    input  wire logic                    rd_ready,
    output sha512_pkg::sched_beat_t      rd_beat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha512_pkg::sched_beat_t mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   fill_reg;
    logic          wr_en, rd_en;

    assign wr_ready = (fill_reg != DEPTH[AW:0]);
    assign rd_valid = (fill_reg != '0);
    assign rd_beat  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    // storage
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wp_reg] <= wr_beat;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
        end else begin
            if (wr_en) begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd_en) begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            fill_reg <= fill_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

endmodule

`default_nettype wire

/* rtl/sha512_core.sv */
// sha512_core: gathers 16 schedule words, runs one round a cycle, emits the digest
// depends on sha512_pkg for constants, initial values and state type
`timescale 1ns / 1ps
`default_nettype none

module sha512_core #(
    parameter int ROUNDS = sha512_pkg::ROUNDS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    restart,
    input  wire logic [1:0]              variant,
    input  wire logic                    q_valid,
    output logic                         q_ready,
    input  wire sha512_pkg::sched_beat_t q_beat,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [63:0]                  m_digest_word,
    output logic [2:0]                   m_word_index,
    output logic                         m_digest_done
);

    localparam int RW = $clog2(ROUNDS + 1);

    sha512_pkg::core_state_t state_reg, state_next;
    logic [63:0] w_reg [16];
    logic [63:0] h_reg [8];
    logic [63:0] v_reg [8];
    logic [3:0]  pos_reg;
    logic        fin_reg;
    logic [RW-1:0] t_reg;
    logic [2:0]  idx_reg;
    logic [63:0] w2, w15, s0, s1, wnew, wt, t1, t2, e, a;
    logic [63:0] dout;

    // message schedule and round function
    always_comb begin
        w2   = w_reg[4'd14];
        w15  = w_reg[4'd1];
        s1   = {w2[18:0], w2[63:19]} ^ {w2[60:0], w2[63:61]} ^ (w2 >> 6);
        s0   = {w15[0], w15[63:1]} ^ {w15[7:0], w15[63:8]} ^ (w15 >> 7);
        wnew = s1 + w_reg[4'd9] + s0 + w_reg[4'd0];
        wt   = w_reg[4'd0];
        e    = v_reg[4];
        a    = v_reg[0];
        t1   = v_reg[7] + ({e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]})
             + ((e & v_reg[5]) ^ (~e & v_reg[6])) + sha512_pkg::round_const(t_reg[6:0]) + wt;
        t2   = ({a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]})
             + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        dout = h_reg[idx_reg];
        if (variant == sha512_pkg::VAR_SHA512_224 && idx_reg == 3'd3) begin
            dout[31:0] = 32'h0;
        end
    end

    assign q_ready       = (state_reg == sha512_pkg::CORE_LOAD);
    assign m_valid       = (state_reg == sha512_pkg::CORE_EMIT);
    assign m_digest_word = dout;
    assign m_word_index  = idx_reg;
    assign m_digest_done = (idx_reg == sha512_pkg::last_index(variant));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sha512_pkg::CORE_LOAD: begin
                if (q_valid && pos_reg == 4'd15) begin
                    state_next = sha512_pkg::CORE_ROUND;
                end
            end
            sha512_pkg::CORE_ROUND: begin
                if (t_reg == RW'(ROUNDS - 1)) begin
                    state_next = sha512_pkg::CORE_ADD;
                end
            end
            sha512_pkg::CORE_ADD: begin
                state_next = fin_reg ? sha512_pkg::CORE_EMIT : sha512_pkg::CORE_LOAD;
            end
            sha512_pkg::CORE_EMIT: begin
                if (m_ready && m_digest_done) begin
                    state_next = sha512_pkg::CORE_LOAD;
                end
            end
            default: state_next = sha512_pkg::CORE_LOAD;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            state_reg <= sha512_pkg::CORE_LOAD;
            pos_reg   <= '0;
            fin_reg   <= 1'b0;
            t_reg     <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == sha512_pkg::CORE_LOAD && q_valid) begin
                pos_reg <= pos_reg + 4'd1;
                fin_reg <= q_beat.final_word;
            end
            if (state_reg == sha512_pkg::CORE_ROUND) begin
                t_reg <= t_reg + 1'b1;
            end else begin
                t_reg <= '0;
            end
            if (state_reg == sha512_pkg::CORE_EMIT && m_ready) begin
                idx_reg <= m_digest_done ? 3'd0 : idx_reg + 3'd1;
            end
        end
    end

    // hash values: reload on reset, restart or digest end
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 8; i++) begin
            if (!aresetn) begin
                h_reg[i] <= sha512_pkg::init_value(sha512_pkg::VAR_SHA512, 3'(i));
            end else if (restart) begin
                h_reg[i] <= sha512_pkg::init_value(variant, 3'(i));
            end else if (state_reg == sha512_pkg::CORE_ADD) begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end else if (state_reg == sha512_pkg::CORE_EMIT && m_ready && m_digest_done) begin
                h_reg[i] <= sha512_pkg::init_value(variant, 3'(i));
            end
        end
    end

    // schedule window shifts one word per round or load beat; working variables
    always_ff @(posedge aclk) begin
        if (state_reg == sha512_pkg::CORE_LOAD && q_valid) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= q_beat.word;
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= h_reg[i];
            end
        end else if (state_reg == sha512_pkg::CORE_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wnew;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule

`default_nettype wire

/* rtl/sha512_family_hash_top.sv */
// Top level of the SHA-512 family hash engine (SHA-512, SHA-384, SHA-512/224, SHA-512/256).
// A message word beat is taken when the schedule queue has room and the front is not sending
// padding or length; the core then loads a block of 16 words, compresses it in ROUNDS (80)
// rounds and adds it in, with the single round unit setting the pace. The last word adds
// padding and length beats (one or two blocks), then 8/6/4/4 digest beats are shown one per
// cycle while m_ready is high. Writing the variant restarts the engine and drops any message;
// input beats are held off during the restart cycle that follows the write.
`timescale 1ns / 1ps
`default_nettype none

module sha512_family_hash_top #(
    parameter int ROUNDS = sha512_pkg::ROUNDS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_message_word,
    input  wire logic [3:0]  s_valid_bytes,
    input  wire logic        s_last_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_digest_word,
    output logic [2:0]       m_word_index,
    output logic             m_digest_done
);

    logic [1:0] variant_reg;
    logic       restart_reg;
    logic       fq_valid, fq_ready, qc_valid, qc_ready;
    sha512_pkg::sched_beat_t fq_beat, qc_beat;

    // variant register; a write restarts the pipeline in the following cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            variant_reg <= sha512_pkg::VAR_SHA512;
            restart_reg <= 1'b0;
        end else begin
            restart_reg <= cfg_we;
            if (cfg_we) begin
                variant_reg <= cfg_wdata;
            end
        end
    end

    sha512_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .restart       (restart_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_message_word(s_message_word),
        .s_valid_bytes (s_valid_bytes),
        .s_last_word   (s_last_word),
        .q_ready       (fq_ready),
        .q_valid       (fq_valid),
        .q_beat        (fq_beat)
    );

    sha512_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (restart_reg),
        .wr_valid(fq_valid),
        .wr_ready(fq_ready),
        .wr_beat (fq_beat),
        .rd_valid(qc_valid),
        .rd_ready(qc_ready),
        .rd_beat (qc_beat)
    );

    sha512_core #(.ROUNDS(ROUNDS)) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .restart      (restart_reg),
        .variant      (variant_reg),
        .q_valid      (qc_valid),
        .q_ready      (qc_ready),
        .q_beat       (qc_beat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digest_word(m_digest_word),
        .m_word_index (m_word_index),
        .m_digest_done(m_digest_done)
    );

`ifndef ASSERT_OFF
    // a sha-512/224 digest ends on word three with its low half cleared
    a_224_trunc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && variant_reg == sha512_pkg::VAR_SHA512_224 && m_word_index == 3'd3
        |-> m_digest_word[31:0] == 32'h0 && m_digest_done)
        else $error("sha-512/224 last word malformed");
    // word index stays within the digest length
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_word_index <= sha512_pkg::last_index(variant_reg))
        else $error("digest word index out of range");
    // a taken digest beat that is not the last one moves the index on
    a_idx_step: assert property (@(posedge aclk) disable iff (!aresetn || cfg_we)
        m_valid && m_ready && !m_digest_done
        |=> m_valid && m_word_index == $past(m_word_index) + 3'd1)
        else $error("digest words not consecutive");
`endif

endmodule

`default_nettype wire

/* bench/tb.sv */
// tb: self-checking bench for sha512_family_hash_top, all four sha-512 family variants
// depends on sha512_pkg for the variant codes; carries its own hash predictor
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_message_word = '0;
    logic [3:0]  s_valid_bytes = '0;
    logic        s_last_word = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_digest_done;

    typedef struct {
        logic [63:0] word;
        logic [2:0]  index;
        logic        done;
    } digest_beat_t;

    digest_beat_t digest_fifo[$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    logic        stalls_on = 1'b1;

    // predictor state
    logic [1:0]  model_variant;
    logic [63:0] model_hash[8];
    logic [63:0] model_block[16];
    logic [3:0]  model_pos;
    logic [60:0] model_bytes;

    sha512_family_hash_top dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_message_word(s_message_word),
        .s_valid_bytes(s_valid_bytes), .s_last_word(s_last_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_digest_word(m_digest_word),
        .m_word_index(m_word_index), .m_digest_done(m_digest_done)
    );

    always #10 aclk = ~aclk;

    // round constants and initial values
    function automatic logic [63:0] k_of(input int t);
        logic [63:0] kt[80];
        kt = '{
            64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
            64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
            64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
            64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
            64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
            64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
            64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
            64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
            64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
            64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
            64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
            64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
            64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
            64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
            64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
            64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
            64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
            64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
            64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
            64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
        return kt[t];
    endfunction

    function automatic logic [63:0] iv_of(input logic [1:0] v, input int i);
        logic [63:0] ivs[32];
        ivs = '{
            64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
            64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179,
            64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
            64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4,
            64'h8c3d37c819544da2, 64'h73e1996689dcd4d6, 64'h1dfab7ae32ff9c82, 64'h679dd514582f9fcf,
            64'h0f6d2b697bd44da8, 64'h77e36f7304c48942, 64'h3f9d85a86a1d36c8, 64'h1112e6ad91d692a1,
            64'h22312194fc2bf72c, 64'h9f555fa3c84c64c2, 64'h2393b86b6f53b151, 64'h963877195940eabd,
            64'h96283ee2a88effe3, 64'hbe5e1e2553863992, 64'h2b0199fc2c85b8aa, 64'h0eb72ddc81c52ca2};
        return ivs[v * 8 + i];
    endfunction

    function automatic logic [63:0] ror(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic restart_model();
        for (int i = 0; i < 8; i++) model_hash[i] = iv_of(model_variant, i);
        model_pos = '0;
        model_bytes = '0;
    endtask

    // 80 rounds over the buffered block
    task automatic compress_block();
        logic [63:0] v[8];
        logic [63:0] w[16];
        logic [63:0] t1, t2, s0, s1;
        for (int i = 0; i < 8; i++) v[i] = model_hash[i];
        for (int i = 0; i < 16; i++) w[i] = model_block[i];
        for (int t = 0; t < 80; t++) begin
            if (t >= 16) begin
                s1 = ror(w[(t-2)%16], 19) ^ ror(w[(t-2)%16], 61) ^ (w[(t-2)%16] >> 6);
                s0 = ror(w[(t-15)%16], 1) ^ ror(w[(t-15)%16], 8) ^ (w[(t-15)%16] >> 7);
                w[t%16] = s1 + w[(t-7)%16] + s0 + w[t%16];
            end
            t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_of(t) + w[t%16];
            t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) model_hash[i] += v[i];
    endtask

    task automatic append_word(input logic [63:0] w);
        model_block[model_pos] = w;
        model_pos++;
        if (model_pos == 0) compress_block();
    endtask

    // predicts one accepted beat, queues any digest words
    task automatic predict_hash(input logic [63:0] word, input logic [3:0] nb_in,
                                input logic last);
        int nb;
        int n;
        digest_beat_t b;
        if (!last) begin
            model_bytes += 61'd8;
            append_word(word);
            return;
        end
        nb = (nb_in > 8) ? 8 : nb_in;
        model_bytes += 61'(nb);
        if (nb == 0) word = '0;
        else if (nb < 8) word &= ~64'h0 << (64 - 8 * nb);
        if (nb == 8) begin
            append_word(word);
            append_word(64'h8000000000000000);
        end else begin
            append_word(word | (64'h80 << (56 - 8 * nb)));
        end
        while (model_pos != 14) append_word('0);
        append_word('0);
        append_word({model_bytes, 3'b000});
        n = (model_variant == sha512_pkg::VAR_SHA512) ? 8 :
            (model_variant == sha512_pkg::VAR_SHA384) ? 6 : 4;
        for (int k = 0; k < n; k++) begin
            b.word = model_hash[k];
            if (model_variant == sha512_pkg::VAR_SHA512_224 && k == 3) b.word[31:0] = '0;
            b.index = 3'(k);
            b.done = (k == n - 1);
            digest_fifo.push_back(b);
        end
        restart_model();
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // sink side: random ready gaps, check each digest beat
    int ready_wait = 0;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (digest_fifo.size() == 0) begin
                report_mismatch("unexpected digest beat", m_digest_word, '0);
            end else begin
                digest_beat_t e;
                e = digest_fifo.pop_front();
                if (m_digest_word !== e.word) report_mismatch("digest_word", m_digest_word, e.word);
                if (m_word_index !== e.index) report_mismatch("word_index", m_word_index, e.index);
                if (m_digest_done !== e.done) report_mismatch("digest_done", m_digest_done, e.done);
            end
        end
        if (ready_wait > 0) begin
            ready_wait <= ready_wait - 1;
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            if (stalls_on && $urandom_range(4, 0) != 0) begin
                ready_wait <= $urandom_range(4, 1) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog on beats in either direction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // sends one input beat after a random gap; valid stays up for a following beat
    task automatic send_word(input logic [63:0] word, input logic [3:0] nb, input logic last);
        int gap;
        gap = stalls_on ? $urandom_range(4, 0) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_message_word <= word;
        s_valid_bytes <= nb;
        s_last_word <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_hash(word, nb, last);
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_message(input int words, input logic [3:0] nb);
        for (int i = 0; i < words; i++) send_word(rand_word(), 4'd8, 1'b0);
        send_word(rand_word(), nb, 1'b1);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (digest_fifo.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_variant(input logic [1:0] v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        model_variant = v;
        restart_model();
    endtask

    // edge field values, byte counts 0/3/5/7/8/15, padding spill into a second block
    task automatic test_directed();
        send_word('0, 4'd0, 1'b1);
        send_word('1, 4'd8, 1'b1);
        send_word('1, 4'd15, 1'b1);
        send_word('1, 4'd3, 1'b1);
        for (int i = 0; i < 14; i++) send_word('1, 4'd8, 1'b0);
        send_word(64'h0123456789abcdef, 4'd8, 1'b1);
        send_message(15, 4'd7);
        send_word('0, 4'd9, 1'b0);
        send_word('1, 4'd5, 1'b1);
    endtask

    // changing the variant mid message drops the partial block
    task automatic test_abandon();
        for (int i = 0; i < 5; i++) send_word(rand_word(), 4'd8, 1'b0);
        s_valid <= 1'b0;
        repeat (300) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= sha512_pkg::VAR_SHA512_256;
        @(posedge aclk);
        cfg_we <= 1'b0;
        model_variant = sha512_pkg::VAR_SHA512_256;
        restart_model();
        send_message(2, 4'd4);
    endtask

    // random messages, mostly short, a few long
    task automatic test_random(input int items);
        int sent;
        int len;
        sent = 0;
        while (sent < items) begin
            len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 14) : $urandom_range(6, 0);
            send_message(len, 4'($urandom_range(15, 0)));
            sent += len + 1;
            if ($urandom_range(15, 0) == 0) stalls_on = ~stalls_on;
        end
        stalls_on = 1'b1;
    endtask

    initial begin
        model_variant = sha512_pkg::VAR_SHA512;
        restart_model();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        write_variant(sha512_pkg::VAR_SHA384);
        test_directed();
        write_variant(sha512_pkg::VAR_SHA512_224);
        send_message(3, 4'd8);
        send_message(0, 4'd1);
        test_abandon();
        write_variant(sha512_pkg::VAR_SHA512);
        test_random(45);
        write_variant(sha512_pkg::VAR_SHA384);
        test_random(45);
        write_variant(sha512_pkg::VAR_SHA512_224);
        test_random(45);
        write_variant(sha512_pkg::VAR_SHA512_256);
        test_random(45);
        wait_drained();
        if (mismatch_count == 0 && digest_fifo.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

/* sha512_family_hash_top.f */
rtl/sha512_pkg.sv
rtl/sha512_front.sv
rtl/sha512_queue.sv
rtl/sha512_core.sv
rtl/sha512_family_hash_top.sv
bench/tb.sv
